@@ rtl/core/indexed_insert_delete_array_unit_assert.svh @@
// Assertion macros for the indexed insert/delete array unit.
`ifndef INDEXED_INSERT_DELETE_ARRAY_UNIT_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define IIDA_ASSERT(lbl, prop, msg)
`define IIDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/iida_pkg.sv @@
// Types and constants shared by the indexed insert/delete array unit.
package iida_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int KIND_W            = 4;
  localparam int POS_W             = 6;
  localparam int ELEM_W            = 32;
  localparam int STAT_W            = 3;
  localparam int COUNT_W           = 7;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_BACK  = 4'd0,
    K_POP_BACK   = 4'd1,
    K_PUSH_FRONT = 4'd2,
    K_POP_FRONT  = 4'd3,
    K_INSERT     = 4'd4,
    K_REPLACE    = 4'd5,
    K_DELETE     = 4'd6,
    K_TAKE       = 4'd7,
    K_READ       = 4'd8,
    K_FIND       = 4'd9,
    K_CLEAR      = 4'd10
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_SHIFT_UP,
    ACT_SHIFT_DOWN
  } act_t;

  typedef enum logic [1:0] {
    PRB_NONE,
    PRB_AT,
    PRB_MATCH
  } probe_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    act_t   act;
    probe_t probe;
    logic   capture;
  } cell_ctl_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element_in;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  element_out;
    logic [POS_W-1:0]   found_position;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

endpackage

@@ rtl/core/iida_cell.sv @@
// One storage cell of the array: holds an element, shifts with its neighbors, flags probe hits.
module iida_cell import iida_pkg::*; #(
  parameter int EW   = ELEMENT_WIDTH_DEF,
  parameter int IDXW = 6,
  parameter int CW   = 7,
  parameter int IDX  = 0
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [IDXW-1:0] at,
  input  logic [CW-1:0]   cnt,
  input  logic [EW-1:0]   elem,
  input  logic [EW-1:0]   left_i,
  input  logic [EW-1:0]   right_i,
  output logic [EW-1:0]   data_o,
  output logic            hit_o,
  output logic [EW-1:0]   leaf_data_o
);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;
  logic          hit_r;
  logic          hit_nxt;
  logic [EW-1:0] leaf_r;
  logic          is_at;
  logic          past_at;

  always_comb begin
    is_at   = (at == IDXW'(IDX));
    past_at = (IDXW'(IDX) > at);
    data_nxt = data_r;
    case (ctl.act)
      ACT_WRITE: begin
        if (is_at) data_nxt = elem;
      end
      ACT_SHIFT_UP: begin
        if (is_at) data_nxt = elem;
        else if (past_at) data_nxt = left_i;
      end
      ACT_SHIFT_DOWN: begin
        if (is_at || past_at) data_nxt = right_i;
      end
      default: data_nxt = data_r;
    endcase
    case (ctl.probe)
      PRB_AT:    hit_nxt = is_at;
      PRB_MATCH: hit_nxt = (CW'(IDX) < cnt) && (data_r == elem);
      default:   hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.capture) begin
      hit_r  <= hit_nxt;
      leaf_r <= data_r;
    end
  end

  assign data_o      = data_r;
  assign hit_o       = hit_r;
  assign leaf_data_o = leaf_r;

endmodule

@@ rtl/core/iida_tree.sv @@
// Registered first-hit selection tree over the cell probe flags.
module iida_tree import iida_pkg::*; #(
  parameter int EW   = ELEMENT_WIDTH_DEF,
  parameter int IDXW = 6
) (
  input  logic            clk,
  input  logic            leaf_hit  [1<<IDXW],
  input  logic [EW-1:0]   leaf_data [1<<IDXW],
  output logic            root_hit,
  output logic [IDXW-1:0] root_idx,
  output logic [EW-1:0]   root_data
);

  localparam int NLEAF = 1 << IDXW;
  localparam int NODES = 2 * NLEAF - 1;

  logic            node_hit_r  [NLEAF-1];
  logic [IDXW-1:0] node_idx_r  [NLEAF-1];
  logic [EW-1:0]   node_data_r [NLEAF-1];

  logic            all_hit  [NODES];
  logic [IDXW-1:0] all_idx  [NODES];
  logic [EW-1:0]   all_data [NODES];

  always_comb begin
    for (int n = 0; n < NLEAF - 1; n++) begin
      all_hit[n]  = node_hit_r[n];
      all_idx[n]  = node_idx_r[n];
      all_data[n] = node_data_r[n];
    end
    for (int i = 0; i < NLEAF; i++) begin
      all_hit[NLEAF-1+i]  = leaf_hit[i];
      all_idx[NLEAF-1+i]  = IDXW'(i);
      all_data[NLEAF-1+i] = leaf_data[i];
    end
  end

  // left child wins: lower index first
  always_ff @(posedge clk) begin
    for (int n = 0; n < NLEAF - 1; n++) begin
      node_hit_r[n] <= all_hit[2*n+1] | all_hit[2*n+2];
      if (all_hit[2*n+1]) begin
        node_idx_r[n]  <= all_idx[2*n+1];
        node_data_r[n] <= all_data[2*n+1];
      end else begin
        node_idx_r[n]  <= all_idx[2*n+2];
        node_data_r[n] <= all_data[2*n+2];
      end
    end
  end

  assign root_hit  = all_hit[0];
  assign root_idx  = all_idx[0];
  assign root_data = all_data[0];

endmodule

@@ rtl/core/indexed_insert_delete_array_unit.sv @@
// out_valid rises after an accepted beat passes the execute, search and emit states.
// A new beat is accepted only in idle, once the last result is loaded; the search
// waits on the registered first-hit tree from the cell row to the result register.
// A new beat is taken while a finished result waits on the output.
// Reset clears the fill count and control state; cell contents are left as they are.
// Top level of the indexed insert/delete array unit.
`include "indexed_insert_delete_array_unit_assert.svh"

module indexed_insert_delete_array_unit import iida_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int EW    = ELEMENT_WIDTH;
  localparam int IDXW  = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = (CW > POS_W) ? CW : POS_W;
  localparam int NLEAF = 1 << IDXW;
  localparam int LW    = (IDXW > 1) ? $clog2(IDXW) : 1;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   lvl_r;
  logic [CW-1:0]   count_r, count_nxt;
  in_item_t        op_r;
  status_t         status_r, status_nxt;
  probe_t          probe_r;
  out_item_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            accept;
  logic            exec;
  logic            load_out;

  cell_ctl_t       ctl;
  act_t            dec_act;
  probe_t          dec_probe;
  logic [IDXW-1:0] at;
  logic [63:0]     elem_w;
  logic [EW-1:0]   elem;
  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   cnt_w;
  logic [CW-1:0]   count_m1;
  logic            pos_ge;
  logic            empty;
  logic            full;

  logic [EW-1:0]   cell_data [CAPACITY];
  logic            leaf_hit  [NLEAF];
  logic [EW-1:0]   leaf_data [NLEAF];
  logic            root_hit;
  logic [IDXW-1:0] root_idx;
  logic [EW-1:0]   root_data;
  logic [63:0]     rd_w;

  // operation decode
  always_comb begin
    elem_w    = 64'(op_r.element_in);
    elem      = elem_w[EW-1:0];
    pos_w     = PW'(op_r.position);
    cnt_w     = PW'(count_r);
    count_m1  = count_r - CW'(1);
    pos_ge    = (pos_w >= cnt_w);
    empty     = (count_r == '0);
    full      = (count_r == CW'(CAPACITY));
    dec_act   = ACT_NONE;
    dec_probe = PRB_NONE;
    at        = '0;
    count_nxt = count_r;
    status_nxt = STAT_OK;
    unique case (op_r.kind)
      K_PUSH_BACK: begin
        if (full) status_nxt = STAT_FULL;
        else begin
          dec_act   = ACT_WRITE;
          at        = IDXW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end
      K_POP_BACK: begin
        if (empty) status_nxt = STAT_EMPTY;
        else begin
          dec_probe = PRB_AT;
          at        = IDXW'(count_m1);
          count_nxt = count_m1;
        end
      end
      K_PUSH_FRONT: begin
        if (full) status_nxt = STAT_FULL;
        else begin
          dec_act   = ACT_SHIFT_UP;
          count_nxt = count_r + CW'(1);
        end
      end
      K_POP_FRONT: begin
        if (empty) status_nxt = STAT_EMPTY;
        else begin
          dec_act   = ACT_SHIFT_DOWN;
          dec_probe = PRB_AT;
          count_nxt = count_m1;
        end
      end
      K_INSERT, K_REPLACE: begin
        if (pos_ge) begin
          if (full) status_nxt = STAT_FULL;
          else begin
            dec_act   = ACT_WRITE;
            at        = IDXW'(count_r);
            count_nxt = count_r + CW'(1);
          end
        end else if (op_r.kind == K_REPLACE) begin
          dec_act = ACT_WRITE;
          at      = IDXW'(op_r.position);
        end else if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          dec_act   = ACT_SHIFT_UP;
          at        = IDXW'(op_r.position);
          count_nxt = count_r + CW'(1);
        end
      end
      K_DELETE, K_TAKE: begin
        if (empty) status_nxt = STAT_EMPTY;
        else if (pos_ge) begin
          if (op_r.kind == K_DELETE) status_nxt = STAT_RANGE;
          else begin
            dec_probe = PRB_AT;
            at        = IDXW'(count_m1);
            count_nxt = count_m1;
          end
        end else begin
          dec_act   = ACT_SHIFT_DOWN;
          dec_probe = PRB_AT;
          at        = IDXW'(op_r.position);
          count_nxt = count_m1;
        end
      end
      K_READ: begin
        if (empty) status_nxt = STAT_EMPTY;
        else if (pos_ge) status_nxt = STAT_RANGE;
        else begin
          dec_probe = PRB_AT;
          at        = IDXW'(op_r.position);
        end
      end
      K_FIND: begin
        dec_probe = PRB_MATCH;
      end
      K_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
    ctl.act     = exec ? dec_act : ACT_NONE;
    ctl.probe   = dec_probe;
    ctl.capture = exec;
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] left_d;
    logic [EW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    iida_cell #(
      .EW   (EW),
      .IDXW (IDXW),
      .CW   (CW),
      .IDX  (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .at          (at),
      .cnt         (count_r),
      .elem        (elem),
      .left_i      (left_d),
      .right_i     (right_d),
      .data_o      (cell_data[i]),
      .hit_o       (leaf_hit[i]),
      .leaf_data_o (leaf_data[i])
    );
  end

  for (genvar i = CAPACITY; i < NLEAF; i++) begin : g_pad
    assign leaf_hit[i]  = 1'b0;
    assign leaf_data[i] = '0;
  end

  iida_tree #(
    .EW   (EW),
    .IDXW (IDXW)
  ) u_tree (
    .clk       (clk),
    .leaf_hit  (leaf_hit),
    .leaf_data (leaf_data),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_data (root_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_SEARCH;
      S_SEARCH: if (lvl_r == LW'(IDXW - 1)) state_nxt = S_EMIT;
      S_EMIT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    exec     = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_EXEC:   exec = 1'b1;
      S_SEARCH: load_out = 1'b0;
      S_EMIT:   load_out = !out_valid_r || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    rd_w                   = 64'(root_data);
    out_nxt.element_out    = (probe_r == PRB_AT) ? rd_w[ELEM_W-1:0] : '0;
    out_nxt.found_position = (probe_r == PRB_MATCH && root_hit) ? POS_W'(root_idx) : '0;
    out_nxt.count          = COUNT_W'(count_r);
    if (probe_r == PRB_MATCH) out_nxt.status = root_hit ? STAT_OK : STAT_NOTFOUND;
    else out_nxt.status = status_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= (state_r == S_SEARCH) ? lvl_r + LW'(1) : '0;
      out_valid_r <= out_valid_nxt;
      if (exec) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) op_r <= in_data;
    if (exec) begin
      status_r <= status_nxt;
      probe_r  <= dec_probe;
    end
    if (load_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IIDA_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "fill count above capacity")
  `IIDA_ASSERT(a_count_exec, $past(rst_n) && !$stable(count_r) |-> $past(state_r == S_EXEC), "count moved outside execute")
  `IIDA_ASSERT(a_out_from_emit, $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_EMIT), "result raised outside emit")
  `IIDA_ASSERT_NEXT(a_emit_hold, state_r == S_EMIT && out_valid_r && !out_ready, state_r == S_EMIT, "emit left while output blocked")

endmodule

@@ bench/tb_indexed_insert_delete_array_unit.sv @@
// Testbench for the indexed insert/delete array unit: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_indexed_insert_delete_array_unit;
  import iida_pkg::*;

  localparam int TOTAL_BEATS = 1900;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AFTER_BEATS = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    LOAD_GROW,
    LOAD_MIXED,
    LOAD_SHRINK
  } load_mix_t;

  typedef struct {
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
    bit                typed;
    out_item_t         res;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // array contents as the block should hold them
  logic [ELEM_W-1:0] shadow_cells [CAPACITY_DEF];
  int unsigned       shadow_fill = 0;

  out_item_t expected_results [$];
  int        beats_sent = 0;
  int        burst_left = 0;
  int        mismatches = 0;
  int        cycles = 0;

  // typed rows: empty array ops, extremes, error codes; others go to the predictor
  script_row_t directed_script [25] = '{
    '{K_POP_BACK,   6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_EMPTY, 7'd0}},
    '{K_POP_FRONT,  6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_EMPTY, 7'd0}},
    '{K_DELETE,     6'd63, 32'h0,        1'b1, '{32'h0, 6'd0, STAT_EMPTY, 7'd0}},
    '{K_TAKE,       6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_EMPTY, 7'd0}},
    '{K_READ,       6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_EMPTY, 7'd0}},
    '{K_FIND,       6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_NOTFOUND, 7'd0}},
    '{K_PUSH_BACK,  6'd0,  32'hFFFFFFFF, 1'b1, '{32'h0, 6'd0, STAT_OK, 7'd1}},
    '{K_PUSH_FRONT, 6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_OK, 7'd2}},
    '{K_INSERT,     6'd1,  32'hA5A5A5A5, 1'b0, '0},
    '{K_INSERT,     6'd63, 32'h5A5A5A5A, 1'b0, '0},
    '{K_REPLACE,    6'd0,  32'h12345678, 1'b0, '0},
    '{K_REPLACE,    6'd40, 32'h0000FFFF, 1'b0, '0},
    '{K_READ,       6'd2,  32'h0,        1'b1, '{32'hFFFFFFFF, 6'd0, STAT_OK, 7'd5}},
    '{K_READ,       6'd63, 32'h0,        1'b1, '{32'h0, 6'd0, STAT_RANGE, 7'd5}},
    '{K_DELETE,     6'd5,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_RANGE, 7'd5}},
    '{K_FIND,       6'd0,  32'h5A5A5A5A, 1'b0, '0},
    '{K_FIND,       6'd0,  32'hDEADBEEF, 1'b1, '{32'h0, 6'd0, STAT_NOTFOUND, 7'd5}},
    '{K_DELETE,     6'd1,  32'h0,        1'b0, '0},
    '{K_TAKE,       6'd63, 32'h0,        1'b0, '0},
    '{K_TAKE,       6'd0,  32'h0,        1'b0, '0},
    '{K_POP_FRONT,  6'd0,  32'h0,        1'b0, '0},
    '{kind_t'(4'd15), 6'd37, 32'hC3C3C3C3, 1'b1, '{32'h0, 6'd0, STAT_OK, 7'd1}},
    '{K_POP_BACK,   6'd0,  32'h0,        1'b0, '0},
    '{K_PUSH_BACK,  6'd0,  32'h1,        1'b0, '0},
    '{K_CLEAR,      6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, STAT_OK, 7'd0}}
  };

  indexed_insert_delete_array_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic status_t shadow_append(logic [ELEM_W-1:0] value);
    if (shadow_fill >= CAPACITY_DEF) return STAT_FULL;
    shadow_cells[shadow_fill] = value;
    shadow_fill++;
    return STAT_OK;
  endfunction

  function automatic void shadow_open(int unsigned at);
    for (int unsigned i = shadow_fill; i > at; i--) shadow_cells[i] = shadow_cells[i - 1];
  endfunction

  function automatic logic [ELEM_W-1:0] shadow_remove(int unsigned at);
    logic [ELEM_W-1:0] value;
    value = shadow_cells[at];
    for (int unsigned i = at; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i + 1];
    shadow_fill--;
    return value;
  endfunction

  function automatic out_item_t predict_array_op(in_item_t op);
    out_item_t   res;
    int unsigned pos;
    res = '0;
    res.status = STAT_OK;
    pos = op.position;
    case (op.kind)
      K_PUSH_BACK: res.status = shadow_append(op.element_in);
      K_POP_BACK, K_POP_FRONT: begin
        if (shadow_fill == 0) res.status = STAT_EMPTY;
        else res.element_out = shadow_remove(op.kind == K_POP_BACK ? shadow_fill - 1 : 0);
      end
      K_PUSH_FRONT, K_INSERT: begin
        if (op.kind == K_PUSH_FRONT) pos = 0;
        if (op.kind == K_INSERT && pos >= shadow_fill) begin
          res.status = shadow_append(op.element_in);
        end else if (shadow_fill >= CAPACITY_DEF) begin
          res.status = STAT_FULL;
        end else begin
          shadow_open(pos);
          shadow_cells[pos] = op.element_in;
          shadow_fill++;
        end
      end
      K_REPLACE: begin
        if (pos >= shadow_fill) res.status = shadow_append(op.element_in);
        else shadow_cells[pos] = op.element_in;
      end
      K_DELETE, K_READ: begin
        if (shadow_fill == 0) res.status = STAT_EMPTY;
        else if (pos >= shadow_fill) res.status = STAT_RANGE;
        else if (op.kind == K_DELETE) res.element_out = shadow_remove(pos);
        else res.element_out = shadow_cells[pos];
      end
      K_TAKE: begin
        if (shadow_fill == 0) res.status = STAT_EMPTY;
        else res.element_out = shadow_remove(pos >= shadow_fill ? shadow_fill - 1 : pos);
      end
      K_FIND: begin
        res.status = STAT_NOTFOUND;
        for (int unsigned i = 0; i < shadow_fill; i++) begin
          if (shadow_cells[i] == op.element_in) begin
            res.found_position = POS_W'(i);
            res.status = STAT_OK;
            break;
          end
        end
      end
      K_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    res.count = COUNT_W'(shadow_fill);
    return res;
  endfunction

  function automatic in_item_t random_op(load_mix_t mix);
    in_item_t    op;
    int          roll;
    int          grow_pct;
    int unsigned top;
    grow_pct = (mix == LOAD_GROW) ? 75 : (mix == LOAD_SHRINK) ? 20 : 45;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      op.kind = kind_t'(4'($urandom_range(11, 15)));
    end else if (roll < 4 && mix != LOAD_GROW) begin
      op.kind = K_CLEAR;
    end else if (roll < 4 + grow_pct) begin
      case ($urandom_range(0, 3))
        0: op.kind = K_PUSH_BACK;
        1: op.kind = K_PUSH_FRONT;
        2: op.kind = K_INSERT;
        default: op.kind = K_REPLACE;
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0: op.kind = K_POP_BACK;
        1: op.kind = K_POP_FRONT;
        2: op.kind = K_DELETE;
        3: op.kind = K_TAKE;
        4: op.kind = K_READ;
        default: op.kind = K_FIND;
      endcase
    end
    top = (shadow_fill > 63) ? 63 : shadow_fill;
    if ($urandom_range(0, 3) == 0) op.position = POS_W'($urandom_range(0, 63));
    else op.position = POS_W'($urandom_range(0, top));
    if (op.kind == K_FIND && shadow_fill != 0 && $urandom_range(0, 1) == 1) begin
      op.element_in = shadow_cells[$urandom_range(0, shadow_fill - 1)];
    end else if ($urandom_range(0, 3) == 0) begin
      op.element_in = ELEM_W'($urandom_range(0, 3));
    end else begin
      op.element_in = $urandom;
    end
    return op;
  endfunction

  task automatic send_beat(input in_item_t op, input bit typed, input out_item_t typed_res);
    out_item_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_array_op(op);
    expected_results.push_back(typed ? typed_res : predicted);
    burst_left--;
    beats_sent++;
  endtask

  // receiver: stall density changes over time, one long hold to back up the input
  initial begin
    int  stall_pct;
    int  mode_left;
    bit  hold_done;
    stall_pct = 0;
    mode_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && beats_sent >= HOLD_AFTER_BEATS) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.element_out !== want.element_out) begin
          $display("%0t: element_out mismatch, expected %h, actual %h", $time,
                   want.element_out, out_data.element_out);
          mismatches++;
        end
        if (out_data.found_position !== want.found_position) begin
          $display("%0t: found_position mismatch, expected %0d, actual %0d", $time,
                   want.found_position, out_data.found_position);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.status, out_data.status);
          mismatches++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d", $time,
                   want.count, out_data.count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    load_mix_t mix;
    int        phase_left;
    in_item_t  op;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_script[i]) begin
      op.kind = directed_script[i].kind;
      op.position = directed_script[i].pos;
      op.element_in = directed_script[i].elem;
      send_beat(op, directed_script[i].typed, directed_script[i].res);
    end
    mix = LOAD_GROW;
    while (beats_sent < TOTAL_BEATS) begin
      phase_left = $urandom_range(60, 200);
      while (phase_left > 0 && beats_sent < TOTAL_BEATS) begin
        send_beat(random_op(mix), 1'b0, '0);
        phase_left--;
      end
      case (mix)
        LOAD_GROW: mix = LOAD_MIXED;
        LOAD_MIXED: mix = LOAD_SHRINK;
        default: mix = LOAD_GROW;
      endcase
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
